/* sv/lsvp_pkg.sv */
// ----------------------------------------------------------------------------
// lsvp_pkg
// Shared types and constants for the layered sample voice player.
// ----------------------------------------------------------------------------
package lsvp_pkg;

    // Command codes on the input channel.
    typedef enum logic [1:0] {
        OP_TICK    = 2'd0,
        OP_TRIGGER = 2'd1,
        OP_LOAD    = 2'd2,
        OP_CLEAR   = 2'd3
    } t_opcode;

    // Configuration register indexes.
    localparam logic [1:0] REG_LAYER_A = 2'd0;
    localparam logic [1:0] REG_LAYER_B = 2'd1;
    localparam logic [1:0] REG_LAYER_C = 2'd2;
    localparam logic [1:0] REG_DECAY   = 2'd3;

    localparam int WORD_W  = 58;
    localparam int DECAY_W = 33;
    localparam int POS_W   = 36;
    localparam int CFG_W   = 58;

    localparam logic [WORD_W-1:0]  WORD_RESET  = 58'd1099511627780;
    localparam logic [DECAY_W-1:0] DECAY_RESET = 33'd11184;

    // Render sequencer states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_LAYER,
        S_CHECK,
        S_RD0,
        S_RD1,
        S_WAIT,
        S_MUL0,
        S_MUL1,
        S_MUL2,
        S_ACC,
        S_OUT
    } t_state;

endpackage

/* sv/lsvp_ram.sv */
// ----------------------------------------------------------------------------
// lsvp_ram
// Generic single-port synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module lsvp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write at most one entry and read one entry per cycle.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

/* sv/layered_sample_voice_player.sv */
// ----------------------------------------------------------------------------
// layered_sample_voice_player
// Three-layer one-shot sample player with linear interpolation and decay.
// ----------------------------------------------------------------------------
// Usage: a command is transferred when i_start is high and o_busy is low.
// Trigger and clear commands finish at the transfer edge and give no result.
// A load writes the left frame at the transfer edge and the right frame in the
// cycle after, holding o_busy high for that cycle.
// A tick walks the layers one after another. Each layer passes S_LAYER, where
// its envelope drop is registered, and S_CHECK for the length and envelope
// checks; a playing layer then reads two frames per output channel from the
// one-port sample memory in S_RD0, S_RD1 and S_WAIT and runs interpolation,
// gain and envelope through registered multiply stages in S_MUL0, S_MUL1 and
// S_MUL2 before accumulating the channel in S_ACC. After the last layer the
// result is shown in S_OUT for one cycle with o_valid high, and the next
// command can be transferred once the sequencer is back in S_IDLE.
// The receiver cannot stall. Reset clears lengths, positions, play flags
// and the configuration registers to their defaults; the sample memory
// holds no reset value, since frames are read only below a loaded length.
// ----------------------------------------------------------------------------
module layered_sample_voice_player
    import lsvp_pkg::*;
#(
    parameter int LAYERS       = 3,
    parameter int SAMPLE_DEPTH = 1048576,
    parameter int CHANNELS     = 2
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    output logic               o_busy,
    input  logic [1:0]         i_opcode,
    input  logic [1:0]         i_layer_select,
    input  logic [19:0]        i_frame_address,
    input  logic signed [15:0] i_left_sample,
    input  logic signed [15:0] i_right_sample,
    input  logic               i_last_word,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [CFG_W-1:0]   i_cfg_data,
    output logic               o_valid,
    output logic signed [23:0] o_left_out,
    output logic signed [23:0] o_right_out,
    output logic [2:0]         o_active_layers
);

    localparam int AW    = $clog2(SAMPLE_DEPTH);
    localparam int LW    = (LAYERS > 1) ? $clog2(LAYERS) : 1;
    localparam int SLOTS = LAYERS * CHANNELS;
    localparam int SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int MW    = SW + AW;
    localparam int DEPTH = SLOTS * SAMPLE_DEPTH;
    localparam int LENW  = AW + 1;

    t_state r_state, n_state;

    logic [WORD_W-1:0]  r_word [LAYERS];
    logic [DECAY_W-1:0] r_decay;
    logic [LENW-1:0]    r_len  [LAYERS];
    logic [POS_W-1:0]   r_pos  [LAYERS];
    logic [LAYERS-1:0]  r_play;

    logic [LW-1:0]      r_li;
    logic               r_ch;       // channel being read
    logic               r_second;   // reading the second frame
    logic signed [15:0] r_s0, r_s1;
    logic [16:0]        r_env16;
    logic signed [33:0] r_interp;
    logic signed [50:0] r_prod1;
    logic signed [66:0] r_prod2;
    logic signed [31:0] r_acc [2];
    logic [POS_W:0]     r_drop;

    logic               mem_we;
    logic [MW-1:0]      mem_addr;
    logic [15:0]        mem_wdata, mem_rdata;

    lsvp_ram #(.WIDTH(16), .DEPTH(DEPTH)) u_store (
        .i_clk  (i_clk),
        .i_we   (mem_we),
        .i_addr (mem_addr),
        .i_wdata(mem_wdata),
        .o_rdata(mem_rdata)
    );

    // Fields of the current layer.
    logic [WORD_W-1:0]  cur_word;
    logic [POS_W-1:0]   cur_pos, start_pos, sounded, cur_step;
    logic [19:0]        cur_idx;
    logic               cur_stereo;
    logic [LENW:0]      idx_p1;
    logic [POS_W:0]     pos_sum;

    assign cur_word   = r_word[r_li];
    assign cur_pos    = r_pos[r_li];
    assign cur_idx    = cur_pos[35:16];
    assign start_pos  = {cur_word[37:18], 16'd0};
    assign sounded    = (cur_pos > start_pos) ? cur_pos - start_pos : '0;
    assign cur_step   = {16'd0, cur_word[57:38]};
    assign cur_stereo = cur_word[1] && (CHANNELS > 1);
    assign idx_p1     = (LENW+1)'({1'b0, cur_idx}) + (LENW+1)'(1);
    assign pos_sum    = {1'b0, cur_pos} + {1'b0, cur_step};

    // Load commands write the left frame first and then the right frame from registered copies.
    logic            load_ok;
    logic            r_load2;
    logic [MW-1:0]   r_load_addr;
    logic [15:0]     r_load_right;
    logic [SW-1:0]   rd_slot;
    logic [AW:0]     rd_frame;

    assign load_ok = (32'(i_layer_select) < LAYERS) &&
                     (32'(i_frame_address) < SAMPLE_DEPTH);
    assign rd_slot  = SW'(32'(r_li) * CHANNELS + ((r_ch && cur_stereo) ? CHANNELS - 1 : 0));
    assign rd_frame = (AW+1)'(cur_idx) + (AW+1)'(r_second);

    always_comb begin
        mem_we    = 1'b0;
        mem_wdata = i_left_sample;
        mem_addr  = {rd_slot, rd_frame[AW-1:0]};
        if (r_load2) begin
            mem_we    = 1'b1;
            mem_addr  = r_load_addr;
            mem_wdata = r_load_right;
        end else if (r_state == S_IDLE && i_start && t_opcode'(i_opcode) == OP_LOAD
                     && load_ok) begin
            mem_we   = 1'b1;
            mem_addr = {SW'(32'(i_layer_select) * CHANNELS), AW'(i_frame_address)};
        end
    end

    // Next state of the tick sequencer.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (i_start && !r_load2 && t_opcode'(i_opcode) == OP_TICK)
                         n_state = S_LAYER;
            S_LAYER: n_state = S_CHECK;
            S_CHECK: begin
                if (!r_play[r_li] || idx_p1 >= (LENW+1)'(r_len[r_li]) ||
                    r_drop[POS_W:32] != '0)
                    n_state = (32'(r_li) == LAYERS - 1) ? S_OUT : S_LAYER;
                else
                    n_state = S_RD0;
            end
            S_RD0:   n_state = S_RD1;
            S_RD1:   n_state = S_WAIT;
            S_WAIT:  n_state = S_MUL0;
            S_MUL0:  n_state = S_MUL1;
            S_MUL1:  n_state = S_MUL2;
            S_MUL2:  n_state = S_ACC;
            S_ACC:   n_state = !r_ch ? S_RD0 :
                               ((32'(r_li) == LAYERS - 1) ? S_OUT : S_LAYER);
            S_OUT:   n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Outputs of the sequencer.
    always_comb begin
        o_busy  = (r_state != S_IDLE) || r_load2;
        o_valid = (r_state == S_OUT);
    end

    logic [16:0] env16_next;
    logic [32:0] env_full;
    assign env_full   = 33'h1_0000_0000 - 33'(r_drop);
    assign env16_next = env_full[32:16];

    // Envelope drop for the layer in hand, registered before the check.
    logic [POS_W:0] drop_calc;
    logic [POS_W-1:0] sounded_next;
    assign sounded_next = sounded;
    always_comb begin
        logic [52:0] hi;
        logic [48:0] lo;
        hi = 53'(sounded_next[35:16]) * 53'(r_decay);
        lo = 49'(sounded_next[15:0]) * 49'(r_decay);
        if ((hi + 53'(lo[48:16])) >= 53'h1_0000_0000) drop_calc = {1'b1, 36'd0};
        else drop_calc = (POS_W+1)'(hi + 53'(lo[48:16]));
    end

    // Datapath and state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_decay <= DECAY_RESET;
            r_play  <= '0;
            r_load2 <= 1'b0;
            r_li    <= '0;
            r_ch    <= 1'b0;
            r_second <= 1'b0;
            r_drop  <= {1'b1, 36'd0};
            for (int i = 0; i < LAYERS; i++) begin
                r_word[i] <= WORD_RESET;
                r_len[i]  <= '0;
                r_pos[i]  <= '0;
            end
        end else begin
            r_state <= n_state;
            r_load2 <= 1'b0;
            if (i_cfg_we) begin
                if (i_cfg_index == REG_DECAY) r_decay <= i_cfg_data[DECAY_W-1:0];
                else if (32'(i_cfg_index) < LAYERS) r_word[LW'(i_cfg_index)] <= i_cfg_data;
            end
            if (r_state == S_IDLE && i_start && !r_load2) begin
                unique case (t_opcode'(i_opcode))
                    OP_TRIGGER: begin
                        for (int i = 0; i < LAYERS; i++) begin
                            if (r_len[i] == '0 || r_word[i][0]) r_play[i] <= 1'b0;
                            else begin
                                r_play[i] <= 1'b1;
                                r_pos[i]  <= {r_word[i][37:18], 16'd0};
                            end
                        end
                    end
                    OP_LOAD: if (load_ok) begin
                        r_load2      <= (CHANNELS > 1);
                        r_load_addr  <= {SW'(32'(i_layer_select) * CHANNELS + CHANNELS - 1),
                                         AW'(i_frame_address)};
                        r_load_right <= i_right_sample;
                        if (i_last_word)
                            r_len[LW'(i_layer_select)] <= LENW'(i_frame_address) + LENW'(1);
                    end
                    OP_CLEAR: if (32'(i_layer_select) < LAYERS) begin
                        r_len[LW'(i_layer_select)]  <= '0;
                        r_play[LW'(i_layer_select)] <= 1'b0;
                    end
                    OP_TICK: begin
                        r_li  <= '0;
                        r_acc[0] <= '0;
                        r_acc[1] <= '0;
                    end
                    default: ;
                endcase
            end
            // The drop register is loaded every cycle; the check state reads the value
            // computed in S_LAYER, while the layer index was already stable.
            r_drop <= drop_calc;
            unique case (r_state)
                S_IDLE: ;
                S_LAYER: begin
                    r_ch <= 1'b0;
                    r_second <= 1'b0;
                end
                S_CHECK: begin
                    if (!r_play[r_li] || idx_p1 >= (LENW+1)'(r_len[r_li]) ||
                        r_drop[POS_W:32] != '0) begin
                        r_play[r_li] <= 1'b0;
                        if (32'(r_li) != LAYERS - 1) r_li <= r_li + LW'(1);
                    end else begin
                        r_env16 <= env16_next;
                    end
                end
                S_RD0: r_second <= 1'b1;
                S_RD1: begin
                    r_s0 <= mem_rdata;
                    r_second <= 1'b0;
                end
                S_WAIT: r_s1 <= mem_rdata;
                S_MUL0: r_interp <= (34'(r_s0) <<< 16) +
                                    (34'(r_s1) - 34'(r_s0)) * $signed({18'd0, cur_pos[15:0]});
                S_MUL1: r_prod1 <= 51'(r_interp) * $signed({35'd0, cur_word[17:2]});
                S_MUL2: r_prod2 <= 67'(r_prod1) * $signed({50'd0, r_env16});
                S_ACC: begin
                    r_acc[r_ch] <= r_acc[r_ch] +
                        32'((r_prod2 + 67'sd34359738368) >>> 36);
                    r_ch <= 1'b1;
                    if (r_ch) begin
                        r_pos[r_li] <= pos_sum[POS_W] ? '1 : pos_sum[POS_W-1:0];
                        if (32'(r_li) != LAYERS - 1) r_li <= r_li + LW'(1);
                    end
                end
                S_OUT: ;
                default: ;
            endcase
        end
    end

    // Saturate the mix.
    function automatic logic signed [23:0] sat24(input logic signed [31:0] v);
        if (v > 32'sd8388607) return 24'sd8388607;
        if (v < -32'sd8388608) return -24'sd8388608;
        return v[23:0];
    endfunction

    logic [7:0] play_ext;
    assign play_ext        = 8'(r_play);
    assign o_left_out      = sat24(r_acc[0]);
    assign o_right_out     = sat24(r_acc[1]);
    assign o_active_layers = play_ext[2:0];

endmodule

/* sv/lsvp_checker.sv */
// ----------------------------------------------------------------------------
// lsvp_checker
// Port-level checks of the sample player, bound to the top level.
// ----------------------------------------------------------------------------
module lsvp_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_start,
    input logic       o_busy,
    input logic       o_valid,
    input logic [2:0] o_active_layers
);

    // A result never appears while the block reports idle.
    a_valid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_busy) else $error("result while idle");

    // Results are single-cycle strobes.
    a_valid_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid) else $error("result held");

    // After a result the block is idle again.
    a_idle_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_busy) else $error("busy after result");

    // No command transfer is followed directly by a result.
    a_no_early: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> !o_valid) else $error("result too early");

    // Reset leaves no result on the ports.
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid) else $error("result after reset");

    // The layer activity flags are always known with a result.
    a_active_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !$isunknown(o_active_layers)) else $error("unknown layer flags");

endmodule

bind layered_sample_voice_player lsvp_checker u_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_start        (i_start),
    .o_busy         (o_busy),
    .o_valid        (o_valid),
    .o_active_layers(o_active_layers)
);

/* tb/layered_sample_voice_player_tb.sv */
// ----------------------------------------------------------------------------
// layered_sample_voice_player_tb
// Self-checking testbench for the layered sample voice player. A command
// queue filled at time zero feeds a clocked driver. Every accepted command
// updates a cycle-free model of the player. A clocked monitor compares each
// rendered frame with the oldest predicted frame. Configuration changes are
// made only while the player is idle, between phases of random play.
// ----------------------------------------------------------------------------
module layered_sample_voice_player_tb;
    import lsvp_pkg::*;

    // One queued transfer: either a command or a register write.
    typedef struct {
        bit                 is_cfg;
        t_opcode            op;
        logic [1:0]         sel;
        logic [19:0]        addr;
        logic signed [15:0] left;
        logic signed [15:0] right;
        logic               last;
        logic [1:0]         cfg_idx;
        logic [CFG_W-1:0]   cfg_data;
    } t_item;

    typedef struct {
        logic signed [23:0] left;
        logic signed [23:0] right;
        logic [2:0]         active;
    } t_frame;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_start;
    logic               o_busy;
    logic [1:0]         i_opcode;
    logic [1:0]         i_layer_select;
    logic [19:0]        i_frame_address;
    logic signed [15:0] i_left_sample;
    logic signed [15:0] i_right_sample;
    logic               i_last_word;
    logic               i_cfg_we;
    logic [1:0]         i_cfg_index;
    logic [CFG_W-1:0]   i_cfg_data;
    logic               o_valid;
    logic signed [23:0] o_left_out;
    logic signed [23:0] o_right_out;
    logic [2:0]         o_active_layers;

    layered_sample_voice_player dut (.*);

    t_item  pending_q[$];
    t_frame frames_due_q[$];
    int     err_cnt = 0;
    int     sent_cnt = 0;
    int     quiet_cnt = 0;
    int     n_items = 0;
    int     prefix_len[3];

    // Model state of the player.
    logic [20:0]        len_m[3];
    logic [35:0]        pos_m[3];
    bit                 play_m[3];
    logic [57:0]        word_m[3];
    logic [32:0]        decay_m;
    logic signed [15:0] store_m[int];

    // Clock generation.
    initial i_clk = 1'b0;
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic int store_key(int layer, int ch, int frame);
        return ((layer * 2 + ch) << 20) + frame;
    endfunction

    function automatic logic signed [15:0] store_rd(int layer, int ch, int frame);
        if (store_m.exists(store_key(layer, ch, frame)))
            return store_m[store_key(layer, ch, frame)];
        return 16'sd0;
    endfunction

    // Render one frame over all playing layers and advance their positions.
    function automatic t_frame render_frame();
        t_frame      f;
        longint      acc[2];
        logic [63:0] start_pos, sounded, drop, env16, frac, gain;
        logic [36:0] next_pos;
        longint      s0, s1, interp, prod;
        int          idx, ch;
        bit          stereo;
        acc[0] = 0;
        acc[1] = 0;
        for (int i = 0; i < 3; i++) begin
            if (!play_m[i]) continue;
            idx = pos_m[i][35:16];
            if (64'(idx) + 1 >= 64'(len_m[i])) begin
                play_m[i] = 1'b0;
                continue;
            end
            start_pos = 64'(word_m[i][37:18]) << 16;
            sounded = (64'(pos_m[i]) > start_pos) ? 64'(pos_m[i]) - start_pos : 64'd0;
            drop = (sounded >> 16) * 64'(decay_m)
                 + (((sounded & 64'hFFFF) * 64'(decay_m)) >> 16);
            if (drop >= 64'h1_0000_0000) begin
                play_m[i] = 1'b0;
                continue;
            end
            env16 = (64'h1_0000_0000 - drop) >> 16;
            gain = 64'(word_m[i][17:2]);
            frac = 64'(pos_m[i][15:0]);
            stereo = word_m[i][1];
            for (int c = 0; c < 2; c++) begin
                ch = (c == 1 && stereo) ? 1 : 0;
                s0 = store_rd(i, ch, idx);
                s1 = store_rd(i, ch, idx + 1);
                interp = s0 * 65536 + (s1 - s0) * longint'(frac);
                prod = interp * longint'(gain) * longint'(env16);
                acc[c] += (prod + (longint'(1) << 35)) >>> 36;
            end
            next_pos = 37'(pos_m[i]) + 37'(word_m[i][57:38]);
            pos_m[i] = next_pos[36] ? 36'hF_FFFF_FFFF : next_pos[35:0];
        end
        for (int c = 0; c < 2; c++) begin
            if (acc[c] > 8388607) acc[c] = 8388607;
            if (acc[c] < -8388608) acc[c] = -8388608;
        end
        f.left = acc[0][23:0];
        f.right = acc[1][23:0];
        f.active = {play_m[2], play_m[1], play_m[0]};
        return f;
    endfunction

    // Apply one accepted command to the model.
    function automatic void play_command(t_item it);
        case (it.op)
            OP_TRIGGER: begin
                for (int i = 0; i < 3; i++) begin
                    if (len_m[i] == 0 || word_m[i][0]) begin
                        play_m[i] = 1'b0;
                    end else begin
                        pos_m[i] = 36'(word_m[i][37:18]) << 16;
                        play_m[i] = 1'b1;
                    end
                end
            end
            OP_LOAD: begin
                if (it.sel < 3) begin
                    store_m[store_key(it.sel, 0, it.addr)] = it.left;
                    store_m[store_key(it.sel, 1, it.addr)] = it.right;
                    if (it.last) len_m[it.sel] = 21'(it.addr) + 21'd1;
                end
            end
            OP_CLEAR: begin
                if (it.sel < 3) begin
                    len_m[it.sel] = '0;
                    play_m[it.sel] = 1'b0;
                end
            end
            default: frames_due_q.push_back(render_frame());
        endcase
    endfunction

    function automatic void write_register(logic [1:0] idx, logic [CFG_W-1:0] data);
        case (idx)
            REG_LAYER_A: word_m[0] = data[57:0];
            REG_LAYER_B: word_m[1] = data[57:0];
            REG_LAYER_C: word_m[2] = data[57:0];
            default:     decay_m = data[32:0];
        endcase
    endfunction

    task automatic report(string what, longint want, longint got);
        $display("mismatch on %s: expected %0d, got %0d at %0t", what, want, got, $time);
        err_cnt++;
    endtask

    // Drive commands and register writes from the pending queue.
    always @(posedge i_clk) begin
        bit    fire, keep_start, idle_now;
        t_item it;
        fire = 1'b0;
        keep_start = 1'b0;
        if (!i_rst_n) begin
            i_start <= 1'b0;
            i_cfg_we <= 1'b0;
        end else begin
            fire = i_start && !o_busy;
            if (fire) begin
                play_command(pending_q[0]);
                void'(pending_q.pop_front());
                sent_cnt++;
            end
            keep_start = i_start && !fire;
            idle_now = !(sent_cnt >= 600 && sent_cnt < 800) && ($urandom_range(0, 99) < 15);
            if (!keep_start && !fire && frames_due_q.size() == 0)
                quiet_cnt++;
            else
                quiet_cnt = 0;
            if (!keep_start && pending_q.size() != 0 && pending_q[0].is_cfg) begin
                i_start <= 1'b0;
                if (quiet_cnt >= 48) begin
                    it = pending_q.pop_front();
                    write_register(it.cfg_idx, it.cfg_data);
                    i_cfg_index <= it.cfg_idx;
                    i_cfg_data <= it.cfg_data;
                    i_cfg_we <= 1'b1;
                end else begin
                    i_cfg_we <= 1'b0;
                end
            end else if (!keep_start && pending_q.size() != 0 && !idle_now) begin
                it = pending_q[0];
                i_opcode <= it.op;
                i_layer_select <= it.sel;
                i_frame_address <= it.addr;
                i_left_sample <= it.left;
                i_right_sample <= it.right;
                i_last_word <= it.last;
                i_start <= 1'b1;
                i_cfg_we <= 1'b0;
            end else begin
                i_start <= keep_start;
                i_cfg_we <= 1'b0;
            end
        end
    end

    // Check every rendered frame against the oldest prediction.
    always @(posedge i_clk) begin
        t_frame want;
        if (i_rst_n && o_valid) begin
            if (frames_due_q.size() == 0) begin
                $display("unexpected frame at %0t", $time);
                err_cnt++;
            end else begin
                want = frames_due_q.pop_front();
                if (o_left_out !== want.left) report("left_out", want.left, o_left_out);
                if (o_right_out !== want.right) report("right_out", want.right, o_right_out);
                if (o_active_layers !== want.active)
                    report("active_layers", want.active, o_active_layers);
            end
        end
    end

    // Fields are passed as 32-bit values and cut to their widths here.
    task automatic push_cmd(t_opcode op, logic [31:0] sel, logic [31:0] addr,
                            logic [31:0] l, logic [31:0] r, logic [31:0] last);
        t_item it;
        it.is_cfg = 1'b0;
        it.op = op;
        it.sel = sel[1:0];
        it.addr = addr[19:0];
        it.left = l[15:0];
        it.right = r[15:0];
        it.last = last[0];
        it.cfg_idx = REG_LAYER_A;
        it.cfg_data = '0;
        pending_q.push_back(it);
        n_items++;
    endtask

    task automatic push_cfg(logic [1:0] idx, logic [CFG_W-1:0] data);
        t_item it;
        it.is_cfg = 1'b1;
        it.op = OP_TICK;
        it.sel = '0;
        it.addr = '0;
        it.left = '0;
        it.right = '0;
        it.last = 1'b0;
        it.cfg_idx = idx;
        it.cfg_data = data;
        pending_q.push_back(it);
    endtask

    // Load frames 0 to len-1 of a layer with random content.
    task automatic load_layer(int layer, int len);
        logic [15:0] l, r;
        for (int k = 0; k < len; k++) begin
            case ($urandom_range(0, 5))
                0:       begin l = 16'h8000; r = 16'h7FFF; end
                1:       begin l = 16'h7FFF; r = 16'h8000; end
                default: begin l = 16'($urandom); r = 16'($urandom); end
            endcase
            push_cmd(OP_LOAD, layer, k, l, r, k == len - 1);
        end
        if (len > prefix_len[layer]) prefix_len[layer] = len;
    endtask

    // A command that disturbs a layer without causing a read of unwritten frames.
    task automatic noise_cmd();
        int layer;
        layer = $urandom_range(0, 2);
        case ($urandom_range(0, 4))
            0: push_cmd(OP_LOAD, 2'd3, $urandom, $urandom, $urandom, $urandom);
            1: push_cmd(OP_CLEAR, $urandom_range(0, 3), $urandom, $urandom, $urandom, 1'b0);
            2: push_cmd(OP_LOAD, layer, $urandom, $urandom, $urandom, 1'b0);
            3: if (prefix_len[layer] > 1)
                push_cmd(OP_LOAD, layer, $urandom_range(1, prefix_len[layer] - 1),
                         $urandom, $urandom, 1'b1);
            default: push_cmd(OP_TRIGGER, $urandom, $urandom, $urandom, $urandom, $urandom);
        endcase
    endtask

    function automatic logic [CFG_W-1:0] layer_word(int len, bit extreme);
        logic [15:0] gain;
        logic [19:0] start_frame, step;
        logic        mute;
        mute = ($urandom_range(0, 5) == 0);
        case ($urandom_range(0, 3))
            0:       gain = extreme ? 16'hFFFF : 16'd0;
            1:       gain = 16'hFFFF;
            2:       gain = 16'($urandom_range(0, 16'h2000));
            default: gain = 16'($urandom);
        endcase
        if ($urandom_range(0, 7) == 0) start_frame = 20'($urandom);
        else start_frame = 20'($urandom_range(0, len > 2 ? len - 2 : 0));
        case ($urandom_range(0, 5))
            0:       step = 20'hFFFFF;
            1:       step = extreme ? 20'd0 : 20'd65536;
            default: step = 20'($urandom_range(1, 20'h28000));
        endcase
        return {step, start_frame, gain, 1'($urandom), mute};
    endfunction

    function automatic logic [CFG_W-1:0] decay_word(bit extreme);
        logic [CFG_W-1:0] junk;
        junk = 58'({$urandom, $urandom});
        case ($urandom_range(0, extreme ? 3 : 7))
            0:       return '0;
            1:       return 58'd1;
            2:       return 58'h1_0000_0000;
            3:       return 58'h1_FFFF_FFFF;
            4:       return {junk[57:33], 33'($urandom_range(1, 1 << 20))};
            default: return 58'($urandom_range(1, 1 << 22));
        endcase
    endfunction

    // Stimulus and end of run.
    initial begin
        int lens[3];
        int phase;
        i_rst_n = 1'b0;
        i_start = 1'b0;
        i_opcode = OP_TICK;
        i_layer_select = '0;
        i_frame_address = '0;
        i_left_sample = '0;
        i_right_sample = '0;
        i_last_word = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = REG_LAYER_A;
        i_cfg_data = '0;
        for (int i = 0; i < 3; i++) begin
            len_m[i] = '0;
            pos_m[i] = '0;
            play_m[i] = 1'b0;
            word_m[i] = WORD_RESET;
            prefix_len[i] = 0;
        end
        decay_m = DECAY_RESET;

        // Directed part under the reset configuration.
        push_cmd(OP_TICK, 2'd0, 20'd0, 16'd0, 16'd0, 1'b0);
        push_cmd(OP_LOAD, 2'd0, 20'd0, 16'h8000, 16'h7FFF, 1'b0);
        push_cmd(OP_LOAD, 2'd0, 20'd1, 16'h7FFF, 16'h8000, 1'b0);
        push_cmd(OP_LOAD, 2'd0, 20'd2, 16'hFFFF, 16'h0000, 1'b0);
        push_cmd(OP_LOAD, 2'd0, 20'd3, 16'h0000, 16'hFFFF, 1'b1);
        prefix_len[0] = 4;
        push_cmd(OP_LOAD, 2'd3, 20'd5, 16'h1234, 16'h4321, 1'b1);
        push_cmd(OP_LOAD, 2'd1, 20'hFFFFF, 16'h7FFF, 16'h8000, 1'b0);
        push_cmd(OP_TRIGGER, 2'd0, 20'd0, 16'd0, 16'd0, 1'b0);
        for (int k = 0; k < 4; k++) push_cmd(OP_TICK, 2'd0, 20'd0, 16'd0, 16'd0, 1'b0);
        push_cmd(OP_CLEAR, 2'd3, 20'd0, 16'd0, 16'd0, 1'b0);
        push_cmd(OP_TRIGGER, 2'd0, 20'd0, 16'd0, 16'd0, 1'b0);
        push_cmd(OP_TICK, 2'd0, 20'd0, 16'd0, 16'd0, 1'b0);
        push_cmd(OP_CLEAR, 2'd0, 20'd0, 16'd0, 16'd0, 1'b0);
        push_cmd(OP_TICK, 2'd0, 20'd0, 16'd0, 16'd0, 1'b0);

        // Random phases: new settings, fresh samples, trigger, then play.
        phase = 0;
        while (n_items < 1350) begin
            for (int i = 0; i < 3; i++)
                lens[i] = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 200)
                                                      : $urandom_range(2, 40);
            push_cfg(REG_LAYER_A, layer_word(lens[0], phase < 3));
            push_cfg(REG_LAYER_B, layer_word(lens[1], phase < 3));
            push_cfg(REG_LAYER_C, layer_word(lens[2], phase < 3));
            push_cfg(REG_DECAY, decay_word(phase < 4));
            for (int i = 0; i < 3; i++) begin
                if (phase == 0 || $urandom_range(0, 2) != 0) begin
                    push_cmd(OP_CLEAR, i, $urandom, $urandom, $urandom, $urandom);
                    load_layer(i, lens[i]);
                end
            end
            push_cmd(OP_TRIGGER, $urandom, $urandom, $urandom, $urandom, $urandom);
            for (int k = $urandom_range(15, 60); k > 0; k--) begin
                if ($urandom_range(0, 9) == 0) noise_cmd();
                else push_cmd(OP_TICK, $urandom, $urandom, $urandom, $urandom, $urandom);
            end
            phase++;
        end
        // Leave the reset values behind at the extremes once more.
        push_cfg(REG_DECAY, 58'h3FF_FFFF_FFFF_FFFF);
        push_cfg(REG_LAYER_A, 58'h3FF_FFFF_FFFF_FFFF);
        push_cmd(OP_TICK, 2'd0, 20'd0, 16'd0, 16'd0, 1'b0);

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_q.size() != 0 || i_start || frames_due_q.size() != 0)
            @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        if (err_cnt == 0 && frames_due_q.size() == 0)
            $display("layered_sample_voice_player test passed");
        else
            $display("layered_sample_voice_player test failed");
        $finish;
    end

    // Hard limit on run time.
    initial begin
        #4000000;
        $display("layered_sample_voice_player test failed");
        $finish;
    end

endmodule

/* sim.f */
sv/lsvp_pkg.sv
sv/lsvp_ram.sv
sv/layered_sample_voice_player.sv
sv/lsvp_checker.sv
tb/layered_sample_voice_player_tb.sv
